// ----- rtl/core/vcp_pkg.sv -----
// Shared constants and types for the voice channel picker.
package vcp_pkg;

  localparam int unsigned Voices = 32;
  localparam int unsigned IdxW   = (Voices > 1) ? $clog2(Voices) : 1;

  localparam int unsigned EntW  = 10;
  localparam int unsigned SubW  = 4;
  localparam int unsigned TimeW = 32;
  localparam int unsigned NowW  = 31;
  localparam int unsigned LenW  = 24;
  localparam int unsigned OutIdxW = 5;

  // Key of "no candidate yet": signed time left of 0x7fffffff after sign flip.
  localparam logic [TimeW-1:0] KeyInit  = 32'hFFFF_FFFF;
  localparam logic [TimeW-1:0] SignFlip = 32'h8000_0000;

  localparam logic [2:0] RegListener = 3'd0;

  typedef struct packed {
    logic [EntW-1:0]  owner;
    logic [SubW-1:0]  subch;
    logic             busy;
    logic [TimeW-1:0] end_time;
  } voice_t;

endpackage

// ----- rtl/core/voice_channel_picker_core.sv -----
// Voice channel picker: scans the voice table and claims a mixer voice.
//
// Usage: a request (current time, entity, sub-channel, sound length) is
// transferred on the input channel when in_valid_i is high and in_stall_o
// low. The block then walks the voice table one entry per cycle through the
// single read port of its voice memory, keeps the best candidate, and writes
// the chosen voice back with its new owner and end time. One result transfer
// (found, voice index, same-source mark) follows per request.
// A scan that claims a voice passes through S_SCAN and S_WRITE to S_DONE;
// when none qualifies there is no write-back, and a same-source hit at entry
// k ends the scan there. The next request is taken the cycle after the
// result loads, so requests are paced by the one-entry-per-cycle voice
// memory read.
// The result register parts the two sides: a request may be taken while the
// previous result still waits; a result waiting under out_stall_i holds the
// finished request until the register frees.
// Reset: all voices read as empty (owner 0, sub-channel 0, idle, end 0) via
// per-voice valid bits cleared at once; no clearing pass is needed. The
// listener entity register resets to 0. pready is always high.
module voice_channel_picker_core
  import vcp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [NowW-1:0]      in_current_time_i,
  input  logic [EntW-1:0]      in_entity_i,
  input  logic [SubW-1:0]      in_entity_channel_i,
  input  logic [LenW-1:0]      in_sound_length_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 out_found_o,
  output logic [OutIdxW-1:0]   out_voice_index_o,
  output logic                 out_same_source_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Voices - 1);

  logic [1:0]       state_q, state_d;

  // configuration
  logic [EntW-1:0]  listener_q;
  logic             cfg_wr;

  // latched request
  logic [NowW-1:0]  now_q;
  logic [EntW-1:0]  ent_q;
  logic [SubW-1:0]  sub_q;
  logic [LenW-1:0]  len_q;

  // scan control
  logic [IdxW-1:0]  rd_idx_q;
  logic             issue_done_q;
  logic             issue;
  logic             ev_vld_q;
  logic [IdxW-1:0]  ev_idx_q;

  // voice memory and valid bits
  voice_t           mem_q [Voices];
  logic [Voices-1:0] vld_q;
  voice_t           rd_data_q;
  logic             rd_ok_q;
  voice_t           cur;

  // candidate tracking
  logic [TimeW-1:0] best_key_q;
  logic [IdxW-1:0]  pick_q;
  logic             have_q;
  logic             same_q;
  logic [TimeW-1:0] key;
  logic             hit;
  logic             skip;
  logic             better;
  logic             have_n;

  // result register
  logic             out_valid_q;
  logic             out_found_q;
  logic [OutIdxW-1:0] out_idx_q;
  logic             out_same_q;
  logic             out_load;

  logic             in_xfer;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listener_q <= '0;
    end else if (cfg_wr && paddr[2:2] == RegListener[0:0]) begin
      listener_q <= pwdata[EntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == RegListener[0:0]) begin
      prdata = {{(32-EntW){1'b0}}, listener_q};
    end
  end

  // ---------------- request capture ----------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q <= in_current_time_i;
      ent_q <= in_entity_i;
      sub_q <= in_entity_channel_i;
      len_q <= in_sound_length_i;
    end
  end

  // ---------------- memory read pipeline ----------------
  assign issue = (state_q == S_SCAN) && !issue_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      issue_done_q <= 1'b0;
      ev_vld_q     <= 1'b0;
      ev_idx_q     <= '0;
    end else begin
      ev_vld_q <= issue;
      ev_idx_q <= rd_idx_q;
      if (in_xfer) begin
        rd_idx_q     <= '0;
        issue_done_q <= 1'b0;
      end else if (issue) begin
        if (rd_idx_q == LastIdx) begin
          issue_done_q <= 1'b1;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
    end
  end

  // synchronous read: data and valid bit are registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_idx_q];
    rd_ok_q   <= vld_q[rd_idx_q];
  end

  // write back the claimed voice
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      mem_q[pick_q] <= '{owner:    ent_q,
                         subch:    sub_q,
                         busy:     1'b1,
                         end_time: {1'b0, now_q} + {{(TimeW-LenW){1'b0}}, len_q}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (state_q == S_WRITE) begin
      vld_q[pick_q] <= 1'b1;
    end
  end

  // ---------------- candidate evaluation ----------------
  // A voice never written reads as all zero.
  assign cur    = rd_ok_q ? rd_data_q : '0;
  assign hit    = (sub_q != '0) && (cur.owner == ent_q) && (cur.subch == sub_q);
  assign skip   = (cur.owner == listener_q) && (ent_q != listener_q) && cur.busy;
  assign key    = (cur.end_time - {1'b0, now_q}) ^ SignFlip;
  assign better = !skip && (key < best_key_q);
  assign have_n = have_q | better;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_key_q <= KeyInit;
      pick_q     <= '0;
      have_q     <= 1'b0;
      same_q     <= 1'b0;
    end else if (in_xfer) begin
      best_key_q <= KeyInit;
      pick_q     <= '0;
      have_q     <= 1'b0;
      same_q     <= 1'b0;
    end else if (state_q == S_SCAN && ev_vld_q) begin
      if (hit) begin
        pick_q <= ev_idx_q;
        have_q <= 1'b1;
        same_q <= 1'b1;
      end else if (better) begin
        best_key_q <= key;
        pick_q     <= ev_idx_q;
        have_q     <= 1'b1;
      end
    end
  end

  // ---------------- sequencer ----------------
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (ev_vld_q) begin
          if (hit) begin
            state_d = S_WRITE;
          end else if (ev_idx_q == LastIdx) begin
            state_d = have_n ? S_WRITE : S_DONE;
          end
        end
      end
      S_WRITE: state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= have_q;
      out_idx_q   <= have_q ? OutIdxW'(pick_q) : '0;
      out_same_q  <= have_q & same_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_found_o       = out_found_q;
  assign out_voice_index_o = out_idx_q;
  assign out_same_source_o = out_same_q;

  // ---------------- assertions ----------------
  // A write-back only happens for a chosen voice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> have_q)
    else $error("write-back without a chosen voice");

  // A same-source claim always carries a chosen voice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    same_q |-> have_q)
    else $error("same-source mark without a chosen voice");

  // An empty result carries index 0 and no same-source mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_found_o) |-> (out_voice_index_o == '0 && !out_same_source_o))
    else $error("empty result with stray fields");

  // An accepted request starts the scan from the first voice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_SCAN && rd_idx_q == '0 && !have_q))
    else $error("scan did not start cleanly");

endmodule

// ----- tb/tb_voice_channel_picker_core.sv -----
// Self-checking testbench for the voice channel picker core.
`timescale 1ns / 1ps

module tb_voice_channel_picker_core;
  import vcp_pkg::*;

  // One request as it is offered on the input channel
  typedef struct packed {
    logic [NowW-1:0] now;
    logic [EntW-1:0] ent;
    logic [SubW-1:0] sub;
    logic [LenW-1:0] len;
  } request_t;

  // One result as it leaves the output channel
  typedef struct packed {
    logic               found;
    logic [OutIdxW-1:0] idx;
    logic               same;
  } pick_t;

  // Directed row: request fields, then a typed-in result where one is given
  typedef struct packed {
    logic [NowW-1:0]    now;
    logic [EntW-1:0]    ent;
    logic [SubW-1:0]    sub;
    logic [LenW-1:0]    len;
    logic               typed;
    logic               found;
    logic [OutIdxW-1:0] idx;
    logic               same;
  } stim_row_t;

  // Shapes of random traffic
  typedef enum logic [1:0] {
    TRAFFIC_MIXER,    // running mixer clock, small pool of entities
    TRAFFIC_FILL,     // listener claims every voice it can reach
    TRAFFIC_GUARDED,  // mostly other entities against a guarded table
    TRAFFIC_NOISE     // every field fully random
  } traffic_e;

  localparam int DirRows = 20;

  // Directed part. Typed results: first request after reset takes voice 0 on a
  // tie; a foreign entity skips the listener's busy voice 0 and takes voice 1;
  // the same entity and nonzero sub-channel then takes voice 1 back at once.
  localparam stim_row_t DirTable [DirRows] = '{
    '{31'h0000_0000, 10'd0,     4'd0,  24'h00_0000, 1'b1, 1'b1, 5'd0, 1'b0},
    '{31'h7FFF_FFFF, 10'd1023,  4'd15, 24'hFF_FFFF, 1'b1, 1'b1, 5'd1, 1'b0},
    '{31'h0000_0005, 10'd1023,  4'd15, 24'h00_0003, 1'b1, 1'b1, 5'd1, 1'b1},
    '{31'h0000_0005, 10'd1023,  4'd0,  24'h00_0003, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h0000_0000, 10'd0,     4'd15, 24'hFF_FFFF, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h2AAA_AAAA, 10'h2AA,   4'hA,  24'hAA_AAAA, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h5555_5555, 10'h155,   4'h5,  24'h55_5555, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h5555_5555, 10'h155,   4'h5,  24'h00_0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h7FFF_FFFF, 10'd0,     4'd0,  24'h00_0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h7FFF_FFFF, 10'd1,     4'd1,  24'h00_0001, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h0000_0000, 10'd1,     4'd1,  24'hFF_FFFF, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h0000_0064, 10'd2,     4'd0,  24'h00_000A, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h0000_0064, 10'd3,     4'd0,  24'h00_000A, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h0000_0064, 10'd0,     4'd0,  24'h00_0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h0000_00C8, 10'd1023,  4'd15, 24'h00_0001, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h4000_0000, 10'd512,   4'd8,  24'h80_0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h4000_0000, 10'd512,   4'd9,  24'h80_0000, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h4000_0001, 10'd512,   4'd8,  24'h00_0001, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h3FFF_FFFF, 10'd511,   4'd7,  24'h7F_FFFF, 1'b0, 1'b0, 5'd0, 1'b0},
    '{31'h0000_0000, 10'd1023,  4'd15, 24'h00_0000, 1'b0, 1'b0, 5'd0, 1'b0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [NowW-1:0]    in_current_time_i;
  logic [EntW-1:0]    in_entity_i;
  logic [SubW-1:0]    in_entity_channel_i;
  logic [LenW-1:0]    in_sound_length_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               out_found_o;
  logic [OutIdxW-1:0] out_voice_index_o;
  logic               out_same_source_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the block: voice table and listener register
  voice_t          voice_table [Voices];
  logic [EntW-1:0] listener_copy;

  pick_t           pending_picks[$];   // results still owed by the block
  logic [EntW-1:0] ent_pool [8];       // entities that keep coming back
  logic [31:0]     clock_now;          // running mixer clock
  int              send_idle_pct;
  int              recv_stall_pct;
  int              hold_left;          // cycles left in a receiver hold-off
  int              fail_count;
  int              requests_sent;
  int              results_seen;
  int              same_seen;
  int              none_seen;
  int              listener_writes;

  voice_channel_picker_core DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_current_time_i   (in_current_time_i),
    .in_entity_i         (in_entity_i),
    .in_entity_channel_i (in_entity_channel_i),
    .in_sound_length_i   (in_sound_length_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_found_o         (out_found_o),
    .out_voice_index_o   (out_voice_index_o),
    .out_same_source_o   (out_same_source_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Work out which voice a request claims and update the shadow table.
  // A nonzero sub-channel already held by the same entity wins at once;
  // busy voices of the listener are skipped for any other entity; otherwise
  // the smallest signed time left wins, lowest index on a tie, and a time
  // left of the largest positive value never qualifies.
  function automatic pick_t claim_voice(input request_t req);
    logic [TimeW-1:0] now_w;
    logic [TimeW-1:0] key;
    logic [TimeW-1:0] best_key;
    pick_t            res;
    int               pick;
    logic             have;
    logic             same;
    now_w    = {1'b0, req.now};
    best_key = KeyInit;
    pick     = 0;
    have     = 1'b0;
    same     = 1'b0;
    for (int i = 0; i < Voices; i++) begin
      if (req.sub != '0 && voice_table[i].owner == req.ent &&
          voice_table[i].subch == req.sub) begin
        pick = i;
        have = 1'b1;
        same = 1'b1;
        break;
      end
      if (!(voice_table[i].busy && voice_table[i].owner == listener_copy &&
            req.ent != listener_copy)) begin
        // flip the sign bit so an unsigned compare keeps signed order
        key = (voice_table[i].end_time - now_w) ^ SignFlip;
        if (key < best_key) begin
          best_key = key;
          pick     = i;
          have     = 1'b1;
        end
      end
    end
    res = '0;
    if (have) begin
      voice_table[pick].owner    = req.ent;
      voice_table[pick].subch    = req.sub;
      voice_table[pick].busy     = 1'b1;
      voice_table[pick].end_time = now_w + TimeW'(req.len);
      res.found = 1'b1;
      res.idx   = OutIdxW'(pick);
      res.same  = same;
    end
    return res;
  endfunction

  // Lowest voice not yet held busy by the listener, -1 when all are guarded
  function automatic int first_open_voice();
    for (int i = 0; i < Voices; i++) begin
      if (!(voice_table[i].busy && voice_table[i].owner == listener_copy)) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic request_t next_request(input traffic_e kind);
    request_t req;
    int       v;
    req = '0;
    case (kind)
      TRAFFIC_NOISE: begin
        req.now = NowW'($urandom);
        req.ent = EntW'($urandom);
        req.sub = SubW'($urandom);
        req.len = LenW'($urandom);
      end
      TRAFFIC_FILL: begin
        // aim the clock at the first open voice so it drops to the front
        v = first_open_voice();
        req.now = (v < 0) ? clock_now[NowW-1:0] : voice_table[v].end_time[NowW-1:0];
        req.ent = listener_copy;
        req.sub = '0;
        req.len = LenW'($urandom_range(1, 40000));
      end
      default: begin
        clock_now = clock_now + $urandom_range(0, 3000);
        req.now   = clock_now[NowW-1:0];
        if (kind == TRAFFIC_GUARDED && $urandom_range(0, 3) == 0) begin
          req.ent = listener_copy;
        end else begin
          req.ent = ent_pool[$urandom_range(0, 7)];
        end
        req.sub = ($urandom_range(0, 3) == 0) ? '0 : SubW'($urandom_range(1, 15));
        case ($urandom_range(0, 9))
          0:       req.len = '0;
          1:       req.len = '1;
          default: req.len = LenW'($urandom_range(1, 40000));
        endcase
      end
    endcase
    return req;
  endfunction

  // Offer one request; called at a falling edge and returns at one, valid
  // still high so the next call either holds it or drops it.
  task automatic send_item(input request_t req, input pick_t typed_pick,
                           input logic typed);
    pick_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_current_time_i   <= req.now;
    in_entity_i         <= req.ent;
    in_entity_channel_i <= req.sub;
    in_sound_length_i   <= req.len;
    do @(posedge clk_i); while (in_stall_o);
    // transfer taken: predict in acceptance order
    got = claim_voice(req);
    pending_picks.push_back(typed ? typed_pick : got);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_picks.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the listener register over the APB port, then read it back
  task automatic write_listener(input logic [EntW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegListener;
    pwdata  <= {22'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    listener_copy = value;
    listener_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {22'd0, listener_copy}) begin
      fail_count++;
      $display("%0t: listener readback expected %0d actual %0d",
               $realtime, listener_copy, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_traffic(input traffic_e kind, input int count,
                             input int send_pct, input int stall_pct,
                             input logic pause_mid);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    ent_pool[0] = listener_copy;
    ent_pool[1] = '0;
    ent_pool[2] = '1;
    for (int i = 3; i < 8; i++) ent_pool[i] = EntW'($urandom);
    for (int i = 0; i < count; i++) begin
      if (kind == TRAFFIC_FILL && first_open_voice() < 0) break;
      if (pause_mid && i == count / 2) begin
        // hold the input back until every owed result has come out
        in_valid_i <= 1'b0;
        drain_results();
      end
      send_item(next_request(kind), '0, 1'b0);
    end
    in_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is asked for
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left    = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest owed result
  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_picks.size() == 0) begin
        fail_count++;
        $display("%0t: result with none owed: found %0d index %0d same %0d",
                 $realtime, out_found_o, out_voice_index_o, out_same_source_o);
      end else begin
        want = pending_picks.pop_front();
        if (want.same) same_seen++;
        if (!want.found) none_seen++;
        if (out_found_o !== want.found) begin
          fail_count++;
          $display("%0t: found expected %0d actual %0d",
                   $realtime, want.found, out_found_o);
        end
        if (out_voice_index_o !== want.idx) begin
          fail_count++;
          $display("%0t: voice_index expected %0d actual %0d",
                   $realtime, want.idx, out_voice_index_o);
        end
        if (out_same_source_o !== want.same) begin
          fail_count++;
          $display("%0t: same_source expected %0d actual %0d",
                   $realtime, want.same, out_same_source_o);
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    request_t req;
    pick_t    want;
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    in_current_time_i   = '0;
    in_entity_i         = '0;
    in_entity_channel_i = '0;
    in_sound_length_i   = '0;
    out_stall_i         = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    listener_copy       = '0;
    clock_now           = 32'h1000_0000;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_left           = 0;
    fail_count          = 0;
    requests_sent       = 0;
    results_seen        = 0;
    same_seen           = 0;
    none_seen           = 0;
    listener_writes     = 0;
    for (int i = 0; i < Voices; i++) voice_table[i] = '0;
    for (int i = 0; i < 8; i++) ent_pool[i] = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, back to back with no stalls
    for (int r = 0; r < DirRows; r++) begin
      req.now = DirTable[r].now;
      req.ent = DirTable[r].ent;
      req.sub = DirTable[r].sub;
      req.len = DirTable[r].len;
      want.found = DirTable[r].found;
      want.idx   = DirTable[r].idx;
      want.same  = DirTable[r].same;
      send_item(req, want, DirTable[r].typed);
    end
    in_valid_i <= 1'b0;
    drain_results();

    // Listener at its top value, sender idling often
    write_listener('1);
    run_traffic(TRAFFIC_MIXER, 140, 67, 0, 1'b0);
    drain_results();

    // Let a fresh listener claim the whole table, then let others find none
    write_listener(EntW'($urandom_range(1, 1022)));
    run_traffic(TRAFFIC_FILL, 80, 0, 67, 1'b0);
    drain_results();
    run_traffic(TRAFFIC_GUARDED, 80, 6, 6, 1'b0);
    drain_results();

    // Release the guard; full-range noise with a pause to empty the pipe
    write_listener('0);
    run_traffic(TRAFFIC_NOISE, 150, 0, 0, 1'b1);
    drain_results();

    // Long receiver hold-off while the sender keeps offering
    @(posedge clk_i);
    hold_left = 400;
    @(negedge clk_i);
    run_traffic(TRAFFIC_MIXER, 60, 0, 0, 1'b0);
    drain_results();

    // Run the mixer clock across the top of its 31-bit range
    write_listener(EntW'($urandom));
    clock_now = 32'h7FFF_0000;
    run_traffic(TRAFFIC_MIXER, 150, 0, 67, 1'b0);
    @(negedge clk_i);
    run_traffic(TRAFFIC_MIXER, 150, 6, 6, 1'b0);
    drain_results();

    write_listener('1);
    run_traffic(TRAFFIC_GUARDED, 100, 67, 0, 1'b0);
    drain_results();

    // Let any stray result show itself before the verdict
    repeat (40) @(posedge clk_i);
    $display("Covered %0d requests, %0d results: %0d same-source takes, %0d with no voice.",
             requests_sent, results_seen, same_seen, none_seen);
    $display("Listener written %0d times; hold-off, clock wrap and guarded table included.",
             listener_writes);
    if (fail_count == 0 && pending_picks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
